@@ sv/pbd_pkg.sv @@
// Shared types and constants for the push-button dimmer control block.
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

    localparam logic [6:0] LEVEL_MAX = 7'd100;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PUSH_INTERVAL    = 2'd0,
        CFG_CONTINUE_INTERVAL = 2'd1,
        CFG_STEP_SIZE        = 2'd2
    } pbd_cfg_idx_t;

    typedef struct packed {
        logic [15:0] push_interval_ms;
        logic [15:0] continue_interval_ms;
        logic [6:0]  step_size;
    } pbd_cfg_t;

    typedef struct packed {
        logic        command;
        logic        level;
        logic        set_on;
        logic [31:0] now_ms;
    } pbd_item_t;

    typedef struct packed {
        logic        prev_level;
        logic [31:0] change_time;
        logic        dimming;
        logic [31:0] ramp_time;
        logic        is_on;
        logic [6:0]  brightness;
    } pbd_state_t;

    typedef struct packed {
        logic       pressed_changed;
        logic       pressed;
        logic       switch_changed;
        logic       switch_on;
        logic       dimmer_changed;
        logic [6:0] dimmer_level;
    } pbd_result_t;

endpackage

`default_nettype wire

@@ sv/pbd_cfg.sv @@
// Configuration register file for the push-button dimmer control block.
`timescale 1ns / 1ps
`default_nettype none

module pbd_cfg
    import pbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output pbd_cfg_t         cfg
);

    pbd_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.push_interval_ms     <= 16'd500;
            cfg_reg.continue_interval_ms <= 16'd100;
            cfg_reg.step_size            <= 7'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PUSH_INTERVAL:     cfg_reg.push_interval_ms     <= cfg_data;
                CFG_CONTINUE_INTERVAL: cfg_reg.continue_interval_ms <= cfg_data;
                CFG_STEP_SIZE:         cfg_reg.step_size            <= cfg_data[6:0];
                default:               ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/pbd_step.sv @@
// Next-state and result logic for one button sample or set command.
`timescale 1ns / 1ps
`default_nettype none

module pbd_step
    import pbd_pkg::*;
(
    input  pbd_cfg_t    cfg,
    input  pbd_state_t  state,
    input  pbd_item_t   item,
    output pbd_state_t  state_next,
    output pbd_result_t result
);

    logic [31:0] diff_change;
    logic [31:0] diff_ramp;
    logic        enter_dim;
    logic        dim_active;
    logic [7:0]  up_sum;
    logic [6:0]  up_val;
    logic [6:0]  down_val;

    assign diff_change = item.now_ms - state.change_time;
    assign enter_dim   = !state.dimming && !item.level &&
                         (diff_change > {16'd0, cfg.push_interval_ms});
    assign dim_active  = state.dimming || enter_dim;
    // On entry the ramp timer starts from the moment of the press.
    assign diff_ramp   = enter_dim ? diff_change : (item.now_ms - state.ramp_time);

    assign up_sum   = {1'b0, state.brightness} + {1'b0, cfg.step_size};
    assign up_val   = (up_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : up_sum[6:0];
    assign down_val = (state.brightness > cfg.step_size) ?
                      (state.brightness - cfg.step_size) : 7'd0;

    always_comb
    begin
        state_next            = state;
        result.pressed_changed = 1'b0;
        result.switch_changed  = 1'b0;
        result.dimmer_changed  = 1'b0;

        if (item.command)
        begin
            state_next.is_on      = item.set_on;
            result.switch_changed = 1'b1;
        end
        else if (item.level != state.prev_level)
        begin
            result.pressed_changed = 1'b1;
            // A short press toggles the light fully on or off.
            if (item.level && (diff_change < {16'd0, cfg.push_interval_ms}))
            begin
                state_next.brightness = state.is_on ? 7'd0 : LEVEL_MAX;
                state_next.is_on      = !state.is_on;
                result.switch_changed = 1'b1;
                result.dimmer_changed = 1'b1;
            end
            state_next.prev_level  = item.level;
            state_next.change_time = item.now_ms;
        end
        else
        begin
            if (enter_dim)
            begin
                state_next.dimming   = 1'b1;
                state_next.ramp_time = state.change_time;
            end
            if (dim_active)
            begin
                if (!item.level && (diff_ramp > {16'd0, cfg.continue_interval_ms}))
                begin
                    result.dimmer_changed = 1'b1;
                    state_next.ramp_time  = item.now_ms;
                    if (!state.is_on)
                    begin
                        state_next.brightness = up_val;
                        if (up_val == LEVEL_MAX)
                        begin
                            state_next.is_on      = 1'b1;
                            result.switch_changed = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.brightness = down_val;
                        if (down_val == 7'd0)
                        begin
                            state_next.is_on      = 1'b0;
                            result.switch_changed = 1'b1;
                        end
                    end
                end
                else if (item.level)
                begin
                    state_next.dimming = 1'b0;
                end
            end
        end

        result.pressed      = !state_next.prev_level;
        result.switch_on    = state_next.is_on;
        result.dimmer_level = state_next.brightness;
    end

endmodule

`default_nettype wire

@@ sv/push_button_dimmer_control.sv @@
// Top level of the push-button dimmer control block.
`timescale 1ns / 1ps
`default_nettype none

// Push-button dimmer control: each input transfer is a timestamped button sample
// or a set command, and each produces exactly one result transfer carrying the
// pressed, switch and dimmer state. One item is accepted every clock cycle
// unless the result stream stalls; it passes the input register, then the result
// register. The rate is set by the state update loop, which reads and rewrites
// the button and dimmer state once per item. Configuration writes are taken in
// any cycle but are meant to arrive only while no item is in flight.
module push_button_dimmer_control
    import pbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // level, set_on, now_ms[31:0], zero pad
    input  wire logic [0:0]  s_tuser,   // command
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // pressed_changed, pressed, switch_changed,
                                        // switch_on, dimmer_changed,
                                        // dimmer_level[6:0], zero pad
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    pbd_cfg_t    cfg;
    pbd_item_t   item_reg;
    logic        item_valid_reg;
    pbd_state_t  state_reg;
    pbd_state_t  state_next;
    pbd_result_t result_next;
    pbd_result_t out_reg;
    logic        out_valid_reg;
    logic        advance;

    pbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbd_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // The held item moves on when the result register is free or being emptied.
    assign advance  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.command <= s_tuser[0];
            item_reg.level   <= s_tdata[0];
            item_reg.set_on  <= s_tdata[1];
            item_reg.now_ms  <= s_tdata[33:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_level  <= 1'b1;
            state_reg.change_time <= 32'd0;
            state_reg.dimming     <= 1'b0;
            state_reg.ramp_time   <= 32'd0;
            state_reg.is_on       <= 1'b0;
            state_reg.brightness  <= 7'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.dimmer_level, out_reg.dimmer_changed,
                       out_reg.switch_on, out_reg.switch_changed,
                       out_reg.pressed, out_reg.pressed_changed};

    // A waiting result always reflects the state that its item left behind.
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.pressed == !state_reg.prev_level) &&
                     (out_reg.switch_on == state_reg.is_on) &&
                     (out_reg.dimmer_level == state_reg.brightness))
        else $error("result register out of step with block state");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.dimmer_level <= LEVEL_MAX))
        else $error("dimmer level above maximum");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> s_tready)
        else $error("input not ready while input register is empty");

    a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed item produced no result transfer");

endmodule

`default_nettype wire
